[design/ncp_pkg.sv]
// ncp_pkg: shared types, constants and elaboration helpers for the nmea
// coordinate parser; no dependencies
`default_nettype none

package ncp_pkg;

  // channel widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 1;

  // field and state widths
  localparam int ANGLE_W = 34;
  localparam int QUOT_W  = 33;
  localparam int DEG_W   = 10;
  localparam int CI_W    = 5;
  localparam int FC_W    = 3;

  localparam int FRAC_DIGITS_DEF = 6;
  localparam int MAX_FIELD_CHARS = 16;

  // pi in q60, truncated
  localparam int          PI_W    = 62;
  localparam int          PI_LO_W = 31;
  localparam logic [61:0] PI_Q60  = 62'h3243F6A8885A308D;

  // item kinds on tuser[0]
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_HEMI = 1'b1;

  // ascii codes
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_W    = 8'h57;

  typedef struct packed {
    logic vld;
    logic ok;
    logic neg;
  } ncp_ctl_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  // minute accumulator holds up to three minute digits plus the kept fraction
  function automatic int minute_width(input int frac);
    return $clog2(pow10(frac + 3));
  endfunction

endpackage

`default_nettype wire

[design/ncp_parse.sv]
// ncp_parse: per-character field checks and digit accumulation, plus the
// registered snapshot taken on a hemisphere item; depends on ncp_pkg
`default_nettype none

module ncp_parse #(
  parameter int FRAC_DIGITS = ncp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           acc,
  input  logic                                           adv,
  input  logic                                           func,
  input  logic                                           lon,
  input  logic [7:0]                                     ch,
  output ncp_pkg::ncp_ctl_t                              snap_ctl,
  output logic [ncp_pkg::DEG_W-1:0]                      snap_deg,
  output logic [ncp_pkg::minute_width(FRAC_DIGITS)-1:0]  snap_min,
  output logic [ncp_pkg::FC_W-1:0]                       snap_fc
);

  import ncp_pkg::*;

  localparam int MINW = minute_width(FRAC_DIGITS);

  logic [CI_W-1:0]  ci_r, ci_nxt;
  logic [DEG_W-1:0] deg_r, deg_nxt;
  logic [MINW-1:0]  min_r, min_nxt;
  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic             dot_r, dot_nxt;
  logic             err_r, err_nxt;

  ncp_ctl_t         snap_ctl_r, snap_ctl_nxt;
  logic [DEG_W-1:0] snap_deg_r;
  logic [MINW-1:0]  snap_min_r;
  logic [FC_W-1:0]  snap_fc_r;

  logic             is_digit;
  logic [3:0]       dval;
  logic [CI_W-1:0]  dcount;
  logic             hemi_ok;
  logic             hemi_neg;

  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval     = ch[3:0];
    dcount   = CI_W'(2) + CI_W'(lon);

    ci_nxt  = ci_r;
    deg_nxt = deg_r;
    min_nxt = min_r;
    fc_nxt  = fc_r;
    dot_nxt = dot_r;
    err_nxt = err_r;

    if (acc) begin
      if (func == FUNC_HEMI) begin
        ci_nxt  = '0;
        deg_nxt = '0;
        min_nxt = '0;
        fc_nxt  = '0;
        dot_nxt = 1'b0;
        err_nxt = 1'b0;
      end else if (ci_r >= CI_W'(MAX_FIELD_CHARS)) begin
        err_nxt = 1'b1;
      end else begin
        ci_nxt = ci_r + CI_W'(1);
        if (!err_r) begin
          if (ci_r < dcount) begin
            if (is_digit) begin
              deg_nxt = (deg_r << 3) + (deg_r << 1) + DEG_W'(dval);
            end else begin
              err_nxt = 1'b1;
            end
          end else if (ci_r < dcount + CI_W'(2)) begin
            if (is_digit) begin
              min_nxt = (min_r << 3) + (min_r << 1) + MINW'(dval);
            end else begin
              err_nxt = 1'b1;
            end
          end else if (ci_r == dcount + CI_W'(2)) begin
            if (ch == CH_DOT && !dot_r) begin
              dot_nxt = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (!is_digit) begin
            err_nxt = 1'b1;
          end else if (fc_r < FC_W'(FRAC_DIGITS)) begin
            min_nxt = (min_r << 3) + (min_r << 1) + MINW'(dval);
            fc_nxt  = fc_r + FC_W'(1);
          end
        end
      end
    end
  end

  // hemisphere letter check and close snapshot
  always_comb begin
    if (lon) begin
      hemi_ok  = (ch == CH_E) || (ch == CH_W);
      hemi_neg = (ch == CH_W);
    end else begin
      hemi_ok  = (ch == CH_N) || (ch == CH_S);
      hemi_neg = (ch == CH_S);
    end
    snap_ctl_nxt.vld = acc && (func == FUNC_HEMI);
    snap_ctl_nxt.ok  = !err_r && dot_r && (ci_r >= CI_W'(lon) + CI_W'(5)) && hemi_ok;
    snap_ctl_nxt.neg = hemi_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r       <= '0;
      deg_r      <= '0;
      min_r      <= '0;
      fc_r       <= '0;
      dot_r      <= 1'b0;
      err_r      <= 1'b0;
      snap_ctl_r <= '0;
    end else begin
      if (acc) begin
        ci_r  <= ci_nxt;
        deg_r <= deg_nxt;
        min_r <= min_nxt;
        fc_r  <= fc_nxt;
        dot_r <= dot_nxt;
        err_r <= err_nxt;
      end
      if (adv) begin
        snap_ctl_r <= snap_ctl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      snap_deg_r <= deg_r;
      snap_min_r <= min_r;
      snap_fc_r  <= fc_r;
    end
  end

  assign snap_ctl = snap_ctl_r;
  assign snap_deg = snap_deg_r;
  assign snap_min = snap_min_r;
  assign snap_fc  = snap_fc_r;

endmodule

`default_nettype wire

[design/ncp_angle.sv]
// ncp_angle: pipelined conversion of degrees and minutes to radians in q28,
// constant multiplies then a reciprocal multiply by the odd divisor part; depends on ncp_pkg
`default_nettype none

module ncp_angle #(
  parameter int FRAC_DIGITS = ncp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           adv,
  input  ncp_pkg::ncp_ctl_t                              in_ctl,
  input  logic [ncp_pkg::DEG_W-1:0]                      in_deg,
  input  logic [ncp_pkg::minute_width(FRAC_DIGITS)-1:0]  in_min,
  input  logic [ncp_pkg::FC_W-1:0]                       in_fc,
  output ncp_pkg::ncp_ctl_t                              res_ctl,
  output logic [ncp_pkg::QUOT_W-1:0]                     res_quot
);

  import ncp_pkg::*;

  localparam longint unsigned DIVISOR = 10800 * pow10(FRAC_DIGITS);
  localparam longint unsigned DEG_MUL = 60 * pow10(FRAC_DIGITS);
  localparam int CW   = $clog2(DEG_MUL + 1);
  localparam int MINW = minute_width(FRAC_DIGITS);
  localparam int MW   = $clog2(61000 * pow10(FRAC_DIGITS));
  localparam int PW   = $clog2(pow10(FRAC_DIGITS) + 1);
  localparam int EXW  = $clog2(FRAC_DIGITS + 1);
  localparam int SW   = 128;
  localparam int PPW  = 32 + PI_LO_W;

  // 2^32 * divisor split into a power of two and an odd part
  localparam int              TZ  = FRAC_DIGITS + 4;
  localparam int              SH  = 32 + TZ;
  localparam longint unsigned ODD = DIVISOR >> TZ;
  localparam int              NB  = MW + PI_W - SH;
  localparam int              L   = $clog2(ODD);
  localparam int              MGW = NB + 1;
  localparam int              HB  = (MGW + 1) / 2;
  localparam int              QPW = 2 * HB;
  localparam int              QSW = NB + MGW;

  localparam logic [CW-1:0] DEG_MUL_V = CW'(DEG_MUL);
  // half of the divisor times 2^32, added before the divide to round
  localparam logic [SW-1:0] BIAS      = SW'(DIVISOR) << 31;

  localparam logic [PI_LO_W-1:0] PI_LO = PI_Q60[PI_LO_W-1:0];
  localparam logic [PI_LO_W-1:0] PI_HI = PI_Q60[PI_W-1:PI_LO_W];

  // ceil(2^(NB+L) / ODD), exact quotient for any NB-bit dividend
  localparam logic [MGW-1:0]     MAG    = MGW'(((SW'(1) << (NB + L)) + SW'(ODD) - SW'(1))
                                               / SW'(ODD));
  localparam logic [HB-1:0]      MAG_LO = MAG[HB-1:0];
  localparam logic [MGW-HB-1:0]  MAG_HI = MAG[MGW-1:HB];

  // powers of ten for scaling short fractions
  logic [PW-1:0] pow_tab [FRAC_DIGITS+1];

  for (genvar i = 0; i <= FRAC_DIGITS; i++) begin : g_pow
    assign pow_tab[i] = PW'(pow10(i));
  end

  // stage 2: scaled degree and minute terms
  logic [FC_W-1:0]       exp_full;
  logic [DEG_W+CW-1:0]   pd;
  logic [MINW+PW-1:0]    pm;
  logic [MW-1:0]         prod_deg_r, prod_min_r;
  ncp_ctl_t              c2_r;

  // stage 3: minutes in units of 10^-frac
  logic [MW-1:0]         m_r;
  ncp_ctl_t              c3_r;

  // stage 4: partial products against pi
  logic [63:0]           mpad;
  logic [PPW-1:0]        pp00_r, pp01_r, pp10_r, pp11_r;
  ncp_ctl_t              c4_r;

  // stage 5: dividend scaled down by the power of two
  logic [SW-1:0]         sum;
  logic [NB-1:0]         n_r;
  ncp_ctl_t              c5_r;

  // stage 6: partial products against the reciprocal
  logic [QPW-1:0]        qp00_r, qp01_r, qp10_r, qp11_r;
  ncp_ctl_t              c6_r;

  // stage 7: quotient
  logic [QSW-1:0]        qsum;
  logic [QUOT_W-1:0]     q_r;
  ncp_ctl_t              c7_r;

  always_comb begin
    exp_full = FC_W'(FRAC_DIGITS) - in_fc;
    pd       = in_deg * DEG_MUL_V;
    pm       = in_min * pow_tab[exp_full[EXW-1:0]];
    mpad     = 64'(m_r);
    sum      = SW'(pp00_r) + (SW'(pp01_r) << 31) + (SW'(pp10_r) << 32)
             + (SW'(pp11_r) << 63) + BIAS;
    qsum     = QSW'(qp00_r) + (QSW'(qp01_r) << HB) + (QSW'(qp10_r) << HB)
             + (QSW'(qp11_r) << (2 * HB));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
      c7_r <= '0;
    end else if (adv) begin
      c2_r <= in_ctl;
      c3_r <= c2_r;
      c4_r <= c3_r;
      c5_r <= c4_r;
      c6_r <= c5_r;
      c7_r <= c6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_deg_r <= MW'(pd);
      prod_min_r <= MW'(pm);
      m_r        <= prod_deg_r + prod_min_r;
      pp00_r     <= mpad[31:0] * PI_LO;
      pp01_r     <= mpad[31:0] * PI_HI;
      pp10_r     <= mpad[63:32] * PI_LO;
      pp11_r     <= mpad[63:32] * PI_HI;
      n_r        <= sum[SH+NB-1:SH];
      qp00_r     <= n_r[HB-1:0] * MAG_LO;
      qp01_r     <= n_r[HB-1:0] * MAG_HI;
      qp10_r     <= n_r[NB-1:HB] * MAG_LO;
      qp11_r     <= n_r[NB-1:HB] * MAG_HI;
      q_r        <= qsum[NB+L+QUOT_W-1:NB+L];
    end
  end

  assign res_ctl  = c7_r;
  assign res_quot = q_r;

endmodule

`default_nettype wire

[design/nmea_coordinate_parser.sv]
// nmea_coordinate_parser: top level, stream handshake and result register
// around ncp_parse and ncp_angle; depends on ncp_pkg
//
//   channel  dir  tdata (low bit up)         tuser (low bit up)
//   in_*     in   ch[7:0]                    func, is_longitude
//   out_*    out  angle[33:0], 6 zero bits   valid_res
//
// one item per cycle while in_tready is high; text characters give no result
// a hemisphere item's result reaches out_tvalid through these registers in order:
//   the snapshot, two minute stages, pi partial products, scaled
//   dividend, reciprocal partial products, quotient, output
// the pipeline holds only when a second result reaches its end while the
//   output register still waits for out_tready
// reset clears the field state and all pipeline valid bits
`default_nettype none

module nmea_coordinate_parser #(
  parameter int FRAC_DIGITS = ncp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ncp_pkg::IN_TDATA_W-1:0]     in_tdata,   // ch
  input  logic [ncp_pkg::IN_TUSER_W-1:0]     in_tuser,   // func, is_longitude
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ncp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // angle, zero pad
  output logic [ncp_pkg::OUT_TUSER_W-1:0]    out_tuser   // valid_res
);

  import ncp_pkg::*;

  localparam int MINW = minute_width(FRAC_DIGITS);

  logic              adv;
  logic              acc;

  ncp_ctl_t          snap_ctl;
  logic [DEG_W-1:0]  snap_deg;
  logic [MINW-1:0]   snap_min;
  logic [FC_W-1:0]   snap_fc;

  ncp_ctl_t          res_ctl;
  logic [QUOT_W-1:0] res_quot;

  logic              out_tvalid_r;
  logic [ANGLE_W-1:0] angle_r, angle_nxt;
  logic              valid_res_r;

  assign adv       = !(res_ctl.vld && out_tvalid_r && !out_tready);
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  ncp_parse #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .adv      (adv),
    .func     (in_tuser[0]),
    .lon      (in_tuser[1]),
    .ch       (in_tdata),
    .snap_ctl (snap_ctl),
    .snap_deg (snap_deg),
    .snap_min (snap_min),
    .snap_fc  (snap_fc)
  );

  ncp_angle #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ctl   (snap_ctl),
    .in_deg   (snap_deg),
    .in_min   (snap_min),
    .in_fc    (snap_fc),
    .res_ctl  (res_ctl),
    .res_quot (res_quot)
  );

  always_comb begin
    if (!res_ctl.ok) begin
      angle_nxt = '0;
    end else if (res_ctl.neg) begin
      angle_nxt = ANGLE_W'(0) - ANGLE_W'(res_quot);
    end else begin
      angle_nxt = ANGLE_W'(res_quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv && res_ctl.vld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_ctl.vld) begin
      angle_r     <= angle_nxt;
      valid_res_r <= res_ctl.ok;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(angle_r);
  assign out_tuser  = OUT_TUSER_W'(valid_res_r);

endmodule

`default_nettype wire

[design/ncp_checker.sv]
// ncp_checker: port-level assertions for nmea_coordinate_parser and the bind
// that attaches them; depends on ncp_pkg
`default_nettype none

module ncp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ncp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic [ncp_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  import ncp_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // rejected field carries a zero angle
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("invalid result with nonzero angle");

  // input never blocked while the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // pad bits above the angle stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:ANGLE_W] == '0)
    else $error("nonzero pad bits");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented after reset");

endmodule

bind nmea_coordinate_parser ncp_checker u_ncp_checker (.*);

`default_nettype wire
